// File: rtl/frame_sequence_statistics_core_defines.svh
// Assertion macros shared by the frame sequence statistics RTL.
`ifndef FRAME_SEQUENCE_STATISTICS_CORE_DEFINES_SVH
`define FRAME_SEQUENCE_STATISTICS_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clk_i and disabled during reset.
`define FSS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i and disabled during reset.
`define FSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/fss_pkg.sv
// Types, codes and helpers shared by the frame sequence statistics modules.
`default_nettype none
package fss_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned Steps   = 16;
  localparam int unsigned StepW   = 4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DATAGRAM_LIMIT = 2'd0,
    REG_MAX_PARTS      = 2'd1,
    REG_V3_OVERHEAD    = 2'd2,
    REG_V4_OVERHEAD    = 2'd3
  } fss_reg_e;

  typedef enum logic [1:0] {
    ST_IN_SEQ      = 2'd0,
    ST_OUT_OF_SEQ  = 2'd1,
    ST_FORMAT_ERR  = 2'd2,
    ST_UNKNOWN_VER = 2'd3
  } fss_status_e;

  typedef enum logic {
    OP_DIV = 1'b0,
    OP_MUL = 1'b1
  } fss_op_e;

  localparam logic [15:0] Version3 = 16'd3;
  localparam logic [15:0] Version4 = 16'd4;

  typedef struct packed {
    logic        start;
    fss_op_e     op;
    logic [15:0] a;
    logic [15:0] b;
  } fss_unit_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] result;
  } fss_unit_rsp_t;

  function automatic logic [15:0] swap16(input logic [15:0] v);
    return {v[7:0], v[15:8]};
  endfunction

endpackage
`default_nettype wire

// File: rtl/fss_in_if.sv
// Channel carrying one received frame header.
`default_nettype none
interface fss_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_frame_size;
  logic [15:0] raw_version;
  logic [15:0] raw_packet_number;
  logic [15:0] raw_part_count;
  logic [15:0] raw_part_number;
  logic [15:0] bytes_read;

  modport source (
    output valid, raw_frame_size, raw_version, raw_packet_number,
           raw_part_count, raw_part_number, bytes_read,
    input  ready
  );
  modport sink (
    input  valid, raw_frame_size, raw_version, raw_packet_number,
           raw_part_count, raw_part_number, bytes_read,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/fss_out_if.sv
// Channel carrying one per-frame statistics result.
`default_nettype none
interface fss_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        was_swapped;
  logic        short_read;
  logic [15:0] lost_now;
  logic [31:0] payload_offset;
  logic [15:0] payload_length;
  logic [31:0] received_total;
  logic [31:0] lost_total;
  logic [31:0] out_of_sequence_total;
  logic [31:0] short_read_total;
  logic [31:0] format_error_total;

  modport source (
    output valid, status, was_swapped, short_read, lost_now, payload_offset,
           payload_length, received_total, lost_total, out_of_sequence_total,
           short_read_total, format_error_total,
    input  ready
  );
  modport sink (
    input  valid, status, was_swapped, short_read, lost_now, payload_offset,
           payload_length, received_total, lost_total, out_of_sequence_total,
           short_read_total, format_error_total,
    output ready
  );
endinterface
`default_nettype wire

// File: rtl/fss_shift_unit.sv
// Shared 16-step shift-and-add unit: restoring divide or unsigned multiply.
`default_nettype none
`include "frame_sequence_statistics_core_defines.svh"
module fss_shift_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fss_pkg::fss_unit_req_t req_i,
  output fss_pkg::fss_unit_rsp_t rsp_o
);
  import fss_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic [16:0]      hi_q, hi_d;
  logic [15:0]      lo_q, lo_d;
  logic [15:0]      b_q, b_d;
  fss_op_e          op_q, op_d;

  logic        step_last;
  logic [16:0] add_x;
  logic [16:0] add_y;
  logic        add_cin;
  logic [17:0] add_sum;

  assign step_last = (cnt_q == StepW'(Steps - 1));

  // One adder serves both operations: subtract-compare for divide,
  // conditional add for multiply.
  always_comb begin
    if (op_q == OP_DIV) begin
      add_x   = {hi_q[15:0], lo_q[15]};
      add_y   = ~{1'b0, b_q};
      add_cin = 1'b1;
    end else begin
      add_x   = {1'b0, hi_q[15:0]};
      add_y   = lo_q[0] ? {1'b0, b_q} : 17'd0;
      add_cin = 1'b0;
    end
    add_sum = {1'b0, add_x} + {1'b0, add_y} + {17'd0, add_cin};
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    b_d    = b_q;
    op_d   = op_q;
    done_d = busy_q && step_last && !req_i.start;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      hi_d   = '0;
      lo_d   = req_i.a;
      b_d    = req_i.b;
      op_d   = req_i.op;
    end else if (busy_q) begin
      cnt_d = cnt_q + StepW'(1);
      if (step_last) begin
        busy_d = 1'b0;
      end
      if (op_q == OP_DIV) begin
        // Carry out set means the shifted remainder was not below the divisor.
        if (add_sum[17]) begin
          hi_d = add_sum[16:0];
          lo_d = {lo_q[14:0], 1'b1};
        end else begin
          hi_d = add_x;
          lo_d = {lo_q[14:0], 1'b0};
        end
      end else begin
        hi_d = {1'b0, add_sum[16:1]};
        lo_d = {add_sum[0], lo_q[15:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
    b_q  <= b_d;
    op_q <= op_d;
  end

  assign rsp_o.busy   = busy_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.result = (op_q == OP_DIV) ? {16'd0, lo_q} : {hi_q[15:0], lo_q};

  `FSS_ASSERT_IMPL(a_done_not_busy, done_q, !busy_q, "unit done while still busy")
  `FSS_ASSERT_NEXT(a_done_after_last, busy_q && step_last && !req_i.start, done_q, "no done after last step")
  `FSS_ASSERT_NEXT(a_start_loads, req_i.start, busy_q && cnt_q == '0, "start did not load the unit")

endmodule
`default_nettype wire

// File: rtl/frame_sequence_statistics_core.sv
// Frame sequence statistics: top level with sequencer, counters and ports.
// Usage:
// Frame headers arrive on in_i (valid/ready); one result per header leaves on
// out_o (valid/ready). Configuration registers are written through cfg_we_i,
// cfg_idx_i and cfg_wdata_i; the user must write them only while the block
// is idle, which the block itself leaves unenforced. A header that needs a
// version 3 loss division runs the shared 16-step shift unit twice, first for
// the packet-loss divide and then for the payload-offset multiply, one bit per
// cycle; other valid headers run only the multiply. The block takes one header
// at a time; in_i.ready is high only when the sequencer is idle.
// The result sits in an output register, so a stalled receiver does not hold
// the sequencer; only a second result waits until the first is transferred.
// Reset (rst_ni, asynchronous, active low) clears the counters, the stored
// last header and the output valid, and loads the register defaults: datagram
// limit 1432, max parts 16, both overheads 64.
// Counters are COUNTER_WIDTH bits, saturate, and the low 32 bits are output.
`default_nettype none
`include "frame_sequence_statistics_core_defines.svh"
module frame_sequence_statistics_core #(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fss_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [15:0]                 cfg_wdata_i,
  fss_in_if.sink                      in_i,
  fss_out_if.source                   out_o
);
  import fss_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EVAL = 6'b000010,
    S_DIV  = 6'b000100,
    S_MUL  = 6'b001000,
    S_LOST = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  localparam logic [COUNTER_WIDTH-1:0] CntMax = '1;

  function automatic logic [COUNTER_WIDTH-1:0] sat_add(
    input logic [COUNTER_WIDTH-1:0] c,
    input logic [15:0]              n
  );
    logic [COUNTER_WIDTH+16:0] s;
    s = {17'd0, c} + {{(COUNTER_WIDTH + 1){1'b0}}, n};
    if (s >= {17'd0, CntMax}) begin
      return CntMax;
    end
    return s[COUNTER_WIDTH-1:0];
  endfunction

  state_e state_q, state_d;

  // Configuration registers.
  logic [15:0] limit_q;
  logic [15:0] max_parts_q;
  logic [10:0] v3_ovh_q;
  logic [10:0] v4_ovh_q;

  // Header of the frame in work, already byte-order corrected.
  logic [15:0] size_q, ver_q, pn_q, cnt_q, part_q, rd_q;
  logic        swapped_q;

  // Last accepted header.
  logic        have_last_q;
  logic [15:0] last_pn_q, last_part_q, last_cnt_q;

  logic [COUNTER_WIDTH-1:0] rcv_q, lost_cnt_q, seq_cnt_q, short_cnt_q, fmt_cnt_q;

  // Per-frame results.
  fss_status_e status_q;
  logic        short_q;
  logic [15:0] lost_q;
  logic [15:0] len_q;
  logic [31:0] off_q;

  // Output register.
  logic        out_valid_q;
  logic        out_load;

  logic          in_xfer;
  logic          swap_det;
  fss_unit_req_t unit_req;
  fss_unit_rsp_t unit_rsp;

  // Evaluation of the stored header.
  logic        is3, is4, ver_ok, fmt_err, frame_ok, short_c;
  logic [10:0] ovh;
  logic [15:0] len_c, diff_c, lost_v4;
  logic        pn_gt, pn_next, part_next, wrap_ok, seq_ok, need_div;

  assign in_xfer  = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign swap_det = (in_i.raw_frame_size > limit_q) &&
                    (swap16(in_i.raw_frame_size) == limit_q);

  always_comb begin
    is3       = (ver_q == Version3);
    is4       = (ver_q == Version4);
    ver_ok    = is3 || is4;
    ovh       = is4 ? v4_ovh_q : v3_ovh_q;
    short_c   = (rd_q != size_q);
    fmt_err   = (cnt_q > max_parts_q) || (part_q >= cnt_q) || (size_q > limit_q) ||
                (size_q < {5'd0, ovh});
    frame_ok  = ver_ok && !fmt_err;
    len_c     = size_q - {5'd0, ovh};
    diff_c    = pn_q - last_pn_q;
    pn_gt     = pn_q > last_pn_q;
    pn_next   = ({1'b0, pn_q} == ({1'b0, last_pn_q} + 17'd1));
    part_next = ({1'b0, part_q} == ({1'b0, last_part_q} + 17'd1));
    wrap_ok   = pn_next && (part_q == 16'd0) && (last_cnt_q != 16'd0) &&
                (last_part_q == (last_cnt_q - 16'd1));
    if (is4) begin
      seq_ok = !have_last_q || ((pn_q == last_pn_q) && part_next) || wrap_ok;
    end else begin
      seq_ok = !have_last_q || (pn_next && part_next) || wrap_ok;
    end
    need_div = !is4 && have_last_q && pn_gt && (diff_c > cnt_q);
    lost_v4  = (is4 && have_last_q && pn_gt && (diff_c > 16'd1)) ?
               (diff_c - 16'd1) : 16'd0;
  end

  // Shared unit requests: the loss divide first when needed, then the
  // payload offset multiply.
  always_comb begin
    unit_req.start = 1'b0;
    unit_req.op    = OP_MUL;
    unit_req.a     = part_q;
    unit_req.b     = len_c;
    if (state_q == S_EVAL && frame_ok) begin
      unit_req.start = 1'b1;
      if (need_div) begin
        unit_req.op = OP_DIV;
        unit_req.a  = diff_c;
        unit_req.b  = cnt_q;
      end
    end else if (state_q == S_DIV && unit_rsp.done) begin
      unit_req.start = 1'b1;
    end
  end

  fss_shift_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (unit_req),
    .rsp_o  (unit_rsp)
  );

  assign out_load = (state_q == S_OUT) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (!frame_ok) begin
          state_d = S_OUT;
        end else if (need_div) begin
          state_d = S_DIV;
        end else begin
          state_d = S_MUL;
        end
      end
      S_DIV: begin
        if (unit_rsp.done) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        if (unit_rsp.done) begin
          state_d = S_LOST;
        end
      end
      S_LOST: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state, configuration, counters and last header.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= 16'd1432;
      max_parts_q <= 16'd16;
      v3_ovh_q    <= 11'd64;
      v4_ovh_q    <= 11'd64;
      have_last_q <= 1'b0;
      last_pn_q   <= '0;
      last_part_q <= '0;
      last_cnt_q  <= '0;
      rcv_q       <= '0;
      lost_cnt_q  <= '0;
      seq_cnt_q   <= '0;
      short_cnt_q <= '0;
      fmt_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (fss_reg_e'(cfg_idx_i))
          REG_DATAGRAM_LIMIT: limit_q     <= cfg_wdata_i;
          REG_MAX_PARTS:      max_parts_q <= cfg_wdata_i;
          REG_V3_OVERHEAD:    v3_ovh_q    <= cfg_wdata_i[10:0];
          REG_V4_OVERHEAD:    v4_ovh_q    <= cfg_wdata_i[10:0];
          default: ;
        endcase
      end
      if (state_q == S_EVAL) begin
        rcv_q <= sat_add(rcv_q, 16'd1);
        if (short_c) begin
          short_cnt_q <= sat_add(short_cnt_q, 16'd1);
        end
        if (!frame_ok) begin
          fmt_cnt_q <= sat_add(fmt_cnt_q, 16'd1);
        end else begin
          if (!seq_ok) begin
            seq_cnt_q <= sat_add(seq_cnt_q, 16'd1);
          end
          have_last_q <= 1'b1;
          last_pn_q   <= pn_q;
          last_part_q <= part_q;
          last_cnt_q  <= cnt_q;
        end
      end
      if (state_q == S_LOST && lost_q != 16'd0) begin
        lost_cnt_q <= sat_add(lost_cnt_q, lost_q);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Header capture, per-frame results and the output register.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      swapped_q <= swap_det;
      rd_q      <= in_i.bytes_read;
      if (swap_det) begin
        size_q <= swap16(in_i.raw_frame_size);
        ver_q  <= swap16(in_i.raw_version);
        pn_q   <= swap16(in_i.raw_packet_number);
        cnt_q  <= swap16(in_i.raw_part_count);
        part_q <= swap16(in_i.raw_part_number);
      end else begin
        size_q <= in_i.raw_frame_size;
        ver_q  <= in_i.raw_version;
        pn_q   <= in_i.raw_packet_number;
        cnt_q  <= in_i.raw_part_count;
        part_q <= in_i.raw_part_number;
      end
    end
    if (state_q == S_EVAL) begin
      short_q <= short_c;
      off_q   <= '0;
      if (!ver_ok) begin
        status_q <= ST_UNKNOWN_VER;
        lost_q   <= '0;
        len_q    <= '0;
      end else if (fmt_err) begin
        status_q <= ST_FORMAT_ERR;
        lost_q   <= '0;
        len_q    <= '0;
      end else begin
        status_q <= seq_ok ? ST_IN_SEQ : ST_OUT_OF_SEQ;
        lost_q   <= lost_v4;
        len_q    <= len_c;
      end
    end
    if (state_q == S_DIV && unit_rsp.done) begin
      lost_q <= unit_rsp.result[15:0];
    end
    if (state_q == S_MUL && unit_rsp.done) begin
      off_q <= unit_rsp.result;
    end
    if (out_load) begin
      out_o.status                <= status_q;
      out_o.was_swapped           <= swapped_q;
      out_o.short_read            <= short_q;
      out_o.lost_now              <= lost_q;
      out_o.payload_offset        <= off_q;
      out_o.payload_length        <= len_q;
      out_o.received_total        <= 32'({{32{1'b0}}, rcv_q});
      out_o.lost_total            <= 32'({{32{1'b0}}, lost_cnt_q});
      out_o.out_of_sequence_total <= 32'({{32{1'b0}}, seq_cnt_q});
      out_o.short_read_total      <= 32'({{32{1'b0}}, short_cnt_q});
      out_o.format_error_total    <= 32'({{32{1'b0}}, fmt_cnt_q});
    end
  end

  assign out_o.valid = out_valid_q;

  `FSS_ASSERT_IMPL(a_idle_unit_free, state_q == S_IDLE, !unit_rsp.busy, "shift unit busy while idle")
  `FSS_ASSERT_IMPL(a_done_in_calc, unit_rsp.done, state_q == S_DIV || state_q == S_MUL, "unexpected unit done")
  `FSS_ASSERT_NEXT(a_rcv_counts, in_xfer, ##1 (rcv_q == $past(rcv_q) + 1'b1 || rcv_q == CntMax), "frame not counted")

endmodule
`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench for the frame sequence statistics core.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fss_pkg::*;

  localparam int IdleLimit  = 3000;
  localparam int DrainDelay = 40;

  typedef struct packed {
    logic [15:0] size;
    logic [15:0] version;
    logic [15:0] packet_number;
    logic [15:0] part_count;
    logic [15:0] part_number;
    logic [15:0] bytes_read;
  } frame_hdr_t;

  typedef struct packed {
    fss_status_e status;
    logic        was_swapped;
    logic        short_read;
    logic [15:0] lost_now;
    logic [31:0] payload_offset;
    logic [15:0] payload_length;
    logic [31:0] received_total;
    logic [31:0] lost_total;
    logic [31:0] out_of_sequence_total;
    logic [31:0] short_read_total;
    logic [31:0] format_error_total;
  } frame_stats_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [15:0]         cfg_wdata;

  fss_in_if  frame_ch ();
  fss_out_if stats_ch ();

  frame_sequence_statistics_core #(
    .COUNTER_WIDTH(32)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (frame_ch),
    .out_o      (stats_ch)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Register copies and header history as the block should hold them.
  logic [15:0] cfg_limit     = 16'd1432;
  logic [15:0] cfg_max_parts = 16'd16;
  logic [10:0] cfg_v3_ovh    = 11'd64;
  logic [10:0] cfg_v4_ovh    = 11'd64;
  logic        have_last     = 1'b0;
  logic [15:0] last_pn       = '0;
  logic [15:0] last_part     = '0;
  logic [15:0] last_cnt      = '0;
  logic [31:0] frames_seen   = '0;
  logic [31:0] packets_lost  = '0;
  logic [31:0] seq_breaks    = '0;
  logic [31:0] partial_seen  = '0;
  logic [31:0] format_errors = '0;

  frame_stats_t expected_stats[$];
  int           mismatch_count = 0;
  int           rx_hold_req    = 0;
  logic         tx_steady      = 1'b0;
  logic         rx_steady      = 1'b0;

  // Generator state for well-formed packet streams.
  logic [15:0] strm_pn, strm_cnt, strm_part, strm_ver;

  function automatic logic [31:0] sat_add(input logic [31:0] c, input logic [31:0] n);
    logic [32:0] s;
    s = {1'b0, c} + {1'b0, n};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic frame_hdr_t byte_swapped(input frame_hdr_t f);
    frame_hdr_t r;
    r = f;
    r.size          = {f.size[7:0], f.size[15:8]};
    r.version       = {f.version[7:0], f.version[15:8]};
    r.packet_number = {f.packet_number[7:0], f.packet_number[15:8]};
    r.part_count    = {f.part_count[7:0], f.part_count[15:8]};
    r.part_number   = {f.part_number[7:0], f.part_number[15:8]};
    return r;
  endfunction

  function automatic frame_stats_t predict_frame(input frame_hdr_t h);
    frame_stats_t r;
    frame_hdr_t   f;
    logic [15:0]  ovh, pn_gap;
    logic         v4, in_seq, wrap_ok;
    logic [31:0]  lost;
    r = '0;
    f = h;
    lost = '0;
    r.was_swapped = (h.size > cfg_limit) && ({h.size[7:0], h.size[15:8]} == cfg_limit);
    if (r.was_swapped) begin
      f = byte_swapped(h);
    end
    frames_seen = sat_add(frames_seen, 32'd1);
    r.short_read = (f.bytes_read != f.size);
    if (r.short_read) begin
      partial_seen = sat_add(partial_seen, 32'd1);
    end
    v4  = (f.version == Version4);
    ovh = v4 ? {5'd0, cfg_v4_ovh} : {5'd0, cfg_v3_ovh};
    if (f.version != Version3 && !v4) begin
      r.status = ST_UNKNOWN_VER;
      format_errors = sat_add(format_errors, 32'd1);
    end else if (f.part_count > cfg_max_parts || f.part_number >= f.part_count ||
                 f.size > cfg_limit || f.size < ovh) begin
      r.status = ST_FORMAT_ERR;
      format_errors = sat_add(format_errors, 32'd1);
    end else begin
      // Start of the next packet right after the final part of the previous one.
      wrap_ok = ({1'b0, f.packet_number} == {1'b0, last_pn} + 17'd1) &&
                (f.part_number == 16'd0) && (last_cnt != 16'd0) &&
                (last_part == last_cnt - 16'd1);
      if (have_last && f.packet_number > last_pn) begin
        pn_gap = f.packet_number - last_pn;
        if (!v4 && pn_gap > f.part_count) begin
          lost = pn_gap / f.part_count;
        end else if (v4 && pn_gap > 16'd1) begin
          lost = pn_gap - 16'd1;
        end
      end
      packets_lost = sat_add(packets_lost, lost);
      if (v4) begin
        in_seq = !have_last || wrap_ok ||
                 (f.packet_number == last_pn &&
                  {1'b0, f.part_number} == {1'b0, last_part} + 17'd1);
      end else begin
        in_seq = !have_last || wrap_ok ||
                 ({1'b0, f.packet_number} == {1'b0, last_pn} + 17'd1 &&
                  {1'b0, f.part_number} == {1'b0, last_part} + 17'd1);
      end
      r.status = in_seq ? ST_IN_SEQ : ST_OUT_OF_SEQ;
      if (!in_seq) begin
        seq_breaks = sat_add(seq_breaks, 32'd1);
      end
      r.lost_now       = lost[15:0];
      r.payload_length = f.size - ovh;
      r.payload_offset = {16'd0, f.part_number} * {16'd0, r.payload_length};
      have_last = 1'b1;
      last_pn   = f.packet_number;
      last_part = f.part_number;
      last_cnt  = f.part_count;
    end
    r.received_total        = frames_seen;
    r.lost_total            = packets_lost;
    r.out_of_sequence_total = seq_breaks;
    r.short_read_total      = partial_seen;
    r.format_error_total    = format_errors;
    return r;
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 12) begin
      return 0;
    end else if (r < 18) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  function automatic frame_hdr_t make_hdr(input logic [15:0] ver, input logic [15:0] pn,
                                          input logic [15:0] cnt, input logic [15:0] part,
                                          input logic [15:0] size);
    frame_hdr_t f;
    f.size          = size;
    f.version       = ver;
    f.packet_number = pn;
    f.part_count    = cnt;
    f.part_number   = part;
    f.bytes_read    = size;
    return f;
  endfunction

  function automatic logic [15:0] pick_count();
    int unsigned top;
    top = (cfg_max_parts < 16'd8) ? cfg_max_parts : 8;
    if ($urandom_range(0, 9) == 0) begin
      top = cfg_max_parts;
    end
    return 16'($urandom_range(1, top));
  endfunction

  function automatic logic [15:0] pick_size(input logic [15:0] ovh);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0 || ovh > cfg_limit) begin
      return ovh;
    end else if (r == 1) begin
      return cfg_limit;
    end
    return 16'($urandom_range(ovh, cfg_limit));
  endfunction

  function automatic frame_hdr_t next_stream_frame();
    frame_hdr_t  f;
    int unsigned kind;
    logic [15:0] ovh;
    kind = $urandom_range(0, 99);
    if (kind < 72) begin
      if (int'(strm_part) + 1 < int'(strm_cnt)) begin
        strm_part = strm_part + 16'd1;
        // Version 3 numbers every datagram; version 4 numbers whole packets.
        if (strm_ver == Version3) begin
          strm_pn = strm_pn + 16'd1;
        end
      end else begin
        strm_part = '0;
        strm_pn   = strm_pn + 16'd1;
        strm_cnt  = pick_count();
      end
    end else if (kind < 82) begin
      strm_pn   = strm_pn + 16'($urandom_range(2, 3 * strm_cnt + 4));
      strm_part = '0;
      strm_cnt  = pick_count();
    end else if (kind < 86) begin
      strm_ver  = (strm_ver == Version3) ? Version4 : Version3;
      strm_pn   = strm_pn + 16'd1;
      strm_part = '0;
      strm_cnt  = pick_count();
    end else if (kind < 90) begin
      strm_pn   = strm_pn - 16'($urandom_range(0, 3));
      strm_part = 16'($urandom_range(0, strm_cnt - 1));
    end
    ovh = (strm_ver == Version4) ? {5'd0, cfg_v4_ovh} : {5'd0, cfg_v3_ovh};
    f = make_hdr(strm_ver, strm_pn, strm_cnt, strm_part, pick_size(ovh));
    if (kind >= 97) begin
      f = frame_hdr_t'({$urandom, $urandom, $urandom});
      return f;
    end else if (kind >= 94) begin
      f.version = 16'($urandom_range(0, 65535));
    end else if (kind >= 90) begin
      case ($urandom_range(0, 3))
        0: f.part_count = cfg_max_parts + 16'($urandom_range(1, 100));
        1: f.part_number = f.part_count + 16'($urandom_range(0, 3));
        2: f.size = cfg_limit + 16'($urandom_range(1, 64));
        default: f.size = ovh - 16'd1;
      endcase
      f.bytes_read = f.size;
    end
    if ($urandom_range(0, 7) == 0) begin
      f.bytes_read = 16'($urandom_range(0, 65535));
    end
    if ($urandom_range(0, 7) == 0) begin
      f = byte_swapped(f);
    end
    return f;
  endfunction

  task automatic send_frame(input frame_hdr_t f);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      frame_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    frame_ch.valid             <= 1'b1;
    frame_ch.raw_frame_size    <= f.size;
    frame_ch.raw_version       <= f.version;
    frame_ch.raw_packet_number <= f.packet_number;
    frame_ch.raw_part_count    <= f.part_count;
    frame_ch.raw_part_number   <= f.part_number;
    frame_ch.bytes_read        <= f.bytes_read;
    do @(posedge clk_i); while (frame_ch.ready !== 1'b1);
    expected_stats = {expected_stats, predict_frame(f)};
  endtask

  task automatic settle_results();
    @(negedge clk_i);
    frame_ch.valid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input fss_reg_e idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    case (idx)
      REG_DATAGRAM_LIMIT: cfg_limit = val;
      REG_MAX_PARTS:      cfg_max_parts = val;
      REG_V3_OVERHEAD:    cfg_v3_ovh = val[10:0];
      default:            cfg_v4_ovh = val[10:0];
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_settings(input logic [15:0] limit, input logic [15:0] parts,
                                input logic [15:0] v3_ovh, input logic [15:0] v4_ovh);
    settle_results();
    write_reg(REG_DATAGRAM_LIMIT, limit);
    write_reg(REG_MAX_PARTS, parts);
    write_reg(REG_V3_OVERHEAD, v3_ovh);
    write_reg(REG_V4_OVERHEAD, v4_ovh);
  endtask

  task automatic run_random_frames(input int n);
    strm_ver  = ($urandom_range(0, 1) == 0) ? Version3 : Version4;
    strm_pn   = ($urandom_range(0, 3) == 0) ? 16'(16'hFFF0 + $urandom_range(0, 15))
                                            : 16'($urandom_range(0, 65535));
    strm_part = '0;
    strm_cnt  = pick_count();
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) begin
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
      end
      send_frame(next_stream_frame());
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    settle_results();
  endtask

  task automatic test_sequence_rules();
    send_frame(make_hdr(Version3, 16'd0, 16'd2, 16'd0, 16'd1432));
    send_frame(make_hdr(Version3, 16'd1, 16'd2, 16'd1, 16'd64));
    send_frame(make_hdr(Version3, 16'd2, 16'd2, 16'd0, 16'd500));
    send_frame(make_hdr(Version4, 16'd2, 16'd3, 16'd1, 16'd700));
    send_frame(make_hdr(Version4, 16'd2, 16'd3, 16'd2, 16'd700));
    send_frame(make_hdr(Version4, 16'd3, 16'd3, 16'd0, 16'd700));
    send_frame(make_hdr(Version4, 16'd7, 16'd3, 16'd0, 16'd900));
    send_frame(make_hdr(Version3, 16'd20, 16'd4, 16'd1, 16'd900));
    send_frame(make_hdr(Version3, 16'd10, 16'd4, 16'd2, 16'd900));
    send_frame(make_hdr(Version3, 16'hFFFF, 16'd1, 16'd0, 16'd1432));
    // Packet numbers do not wrap, so 0 after 65535 is out of order.
    send_frame(make_hdr(Version3, 16'd0, 16'd2, 16'd0, 16'd1000));
    settle_results();
  endtask

  task automatic test_format_errors();
    send_frame(make_hdr(16'd0, 16'd1, 16'd2, 16'd1, 16'd800));
    send_frame(make_hdr(16'hFFFF, 16'd1, 16'd2, 16'd1, 16'd800));
    send_frame(make_hdr(Version3, 16'd1, 16'd17, 16'd1, 16'd800));
    send_frame(make_hdr(Version4, 16'd1, 16'd16, 16'd16, 16'd800));
    send_frame(make_hdr(Version3, 16'd1, 16'd0, 16'd0, 16'd800));
    send_frame(make_hdr(Version3, 16'd1, 16'hFFFF, 16'hFFFF, 16'd800));
    send_frame(make_hdr(Version3, 16'd1, 16'd2, 16'd1, 16'd1433));
    send_frame(make_hdr(Version4, 16'd1, 16'd2, 16'd1, 16'd63));
    settle_results();
  endtask

  task automatic test_swap_and_short_read();
    frame_hdr_t f;
    send_frame(byte_swapped(make_hdr(Version3, 16'd1, 16'd2, 16'd1, 16'd1432)));
    send_frame(byte_swapped(make_hdr(Version4, 16'd2, 16'd5, 16'd0, 16'd1432)));
    f = make_hdr(Version4, 16'd2, 16'd5, 16'd1, 16'd300);
    f.bytes_read = 16'd299;
    send_frame(f);
    f = make_hdr(Version3, 16'd3, 16'd5, 16'd2, 16'd0);
    f.bytes_read = 16'hFFFF;
    send_frame(f);
    send_frame(make_hdr(Version3, 16'd3, 16'd5, 16'd2, 16'hFFFF));
    settle_results();
  endtask

  task automatic test_backpressure();
    rx_hold_req = 300;
    tx_steady   = 1'b1;
    for (int i = 0; i < 8; i++) begin
      send_frame(make_hdr(Version4, 16'd40, 16'd8, 16'(i), 16'(100 + 50 * i)));
    end
    tx_steady = 1'b0;
    settle_results();
  endtask

  task automatic test_default_settings();
    run_random_frames(330);
  endtask

  task automatic test_widest_settings();
    apply_settings(16'hFFFF, 16'hFFFF, 16'd0, 16'd1024);
    run_random_frames(180);
  endtask

  task automatic test_narrowest_settings();
    apply_settings(16'd1, 16'd1, 16'd1, 16'd0);
    run_random_frames(100);
  endtask

  task automatic test_random_settings();
    for (int k = 0; k < 3; k++) begin
      apply_settings(16'($urandom_range(200, 4000)), 16'($urandom_range(1, 64)),
                     16'($urandom_range(0, (k == 2) ? 1024 : 200)),
                     16'($urandom_range(0, (k == 2) ? 1024 : 200)));
      run_random_frames(130);
    end
  endtask

  task automatic check_field(input string fname, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : stats_checker
    frame_stats_t exp_r;
    if (stats_ch.valid === 1'b1 && stats_ch.ready === 1'b1) begin
      if (expected_stats.size() == 0) begin
        $display("%0t: result transfer with no frame outstanding", $time);
        mismatch_count++;
      end else begin
        exp_r = expected_stats.pop_front();
        check_field("status", exp_r.status, stats_ch.status);
        check_field("was_swapped", exp_r.was_swapped, stats_ch.was_swapped);
        check_field("short_read", exp_r.short_read, stats_ch.short_read);
        check_field("lost_now", exp_r.lost_now, stats_ch.lost_now);
        check_field("payload_offset", exp_r.payload_offset, stats_ch.payload_offset);
        check_field("payload_length", exp_r.payload_length, stats_ch.payload_length);
        check_field("received_total", exp_r.received_total, stats_ch.received_total);
        check_field("lost_total", exp_r.lost_total, stats_ch.lost_total);
        check_field("out_of_sequence_total", exp_r.out_of_sequence_total,
                    stats_ch.out_of_sequence_total);
        check_field("short_read_total", exp_r.short_read_total, stats_ch.short_read_total);
        check_field("format_error_total", exp_r.format_error_total,
                    stats_ch.format_error_total);
      end
    end
  end

  // Result receiver: random stalls, plus long hold-offs on request.
  initial begin : result_sink
    int stall;
    stats_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      stall = 0;
      if (rx_hold_req != 0) begin
        stall = rx_hold_req;
        rx_hold_req = 0;
      end else if (!rx_steady) begin
        stall = pick_gap();
      end
      if (stall > 0) begin
        stats_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      stats_ch.ready <= 1'b1;
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((frame_ch.valid === 1'b1 && frame_ch.ready === 1'b1) ||
          (stats_ch.valid === 1'b1 && stats_ch.ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : test_sequence
    rst_ni                     = 1'b0;
    cfg_we                     = 1'b0;
    cfg_idx                    = REG_DATAGRAM_LIMIT;
    cfg_wdata                  = '0;
    frame_ch.valid             = 1'b0;
    frame_ch.raw_frame_size    = '0;
    frame_ch.raw_version       = '0;
    frame_ch.raw_packet_number = '0;
    frame_ch.raw_part_count    = '0;
    frame_ch.raw_part_number   = '0;
    frame_ch.bytes_read        = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_sequence_rules();
    test_format_errors();
    test_swap_and_short_read();
    test_backpressure();
    test_default_settings();
    test_widest_settings();
    test_narrowest_settings();
    test_random_settings();

    settle_results();
    repeat (DrainDelay) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
+incdir+rtl
rtl/fss_pkg.sv
rtl/fss_in_if.sv
rtl/fss_out_if.sv
rtl/fss_shift_unit.sv
rtl/frame_sequence_statistics_core.sv
verif/tb_top.sv
